// ===== design/irpte_pkg.sv =====
// Package for the IR pulse-train encoder: widths, constants and shared types.
// Used by every module of the encoder; depends on nothing.
package irpte_pkg;

	// Field and register widths
	localparam int DUR_W     = 16;
	localparam int CARRIER_W = 18;
	localparam int MAXB_W    = 8;
	localparam int BYTE_W    = 8;
	localparam int OUT_USER_W = 2;
	localparam int CFG_IDX_W = 1;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CARRIER_HZ = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES  = 1'd1;

	// Register reset values and the legal carrier range
	localparam logic [CARRIER_W-1:0] CARRIER_RESET = 18'd38000;
	localparam logic [CARRIER_W-1:0] CARRIER_LOW   = 18'd25000;
	localparam logic [CARRIER_W-1:0] CARRIER_HIGH  = 18'd150000;
	localparam logic [MAXB_W-1:0]    MAXB_RESET    = 8'd150;

	// Period conversion: round(dur * carrier / 1e6), halves rounded up
	localparam int DIV_W  = 34;
	localparam int QUOT_W = 14;
	localparam logic [DIV_W-1:0] US_PER_SECOND = 34'd1000000;
	localparam logic [DIV_W-1:0] ROUND_HALF    = 34'd500000;

	// Divide by one million as a shift by 6 (1e6 = 64 * 15625), then a
	// multiply by ceil(2^42 / 15625); exact for every 28-bit dividend
	localparam int RECIP_PRE   = 6;
	localparam int RECIP_X_W   = DIV_W - RECIP_PRE;
	localparam int RECIP_M_W   = 29;
	localparam int RECIP_SHIFT = 42;
	localparam int RECIP_P_W   = RECIP_X_W + RECIP_M_W;
	localparam logic [RECIP_M_W-1:0] RECIP_M = 29'd281474977;

	// Byte packing
	localparam int PER_W = 13;
	localparam int CNT_W = 9;
	localparam logic [PER_W-1:0] BYTE_PERIODS = 13'd127;
	localparam logic [PER_W-1:0] PERIOD_CAP   = 13'd7620;
	localparam logic [CNT_W-1:0] COUNT_MAX    = 9'd511;

	// Queue depth default between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// One classified item waiting for the back end
	typedef struct packed {
		logic [PER_W-1:0] periods;
		logic             fin;
	} irpte_entry_t;

	// Front-end sequencer states
	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_MUL  = 5'b00010,
		F_RND  = 5'b00100,
		F_DIV  = 5'b01000,
		F_PUSH = 5'b10000
	} front_state_t;

endpackage

// ===== design/irpte_front.sv =====
// Front end of the IR pulse-train encoder: accepts durations and converts
// them to carrier period counts. Depends on irpte_pkg.
module irpte_front import irpte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DUR_W-1:0]     s_tdata,
	input  logic                 s_tlast,
	input  logic [CARRIER_W-1:0] carrier_hz,
	output logic                 push,
	output irpte_entry_t         push_entry,
	input  logic                 full
);

	front_state_t          state_q;
	logic [DUR_W-1:0]      dur_q;
	logic                  fin_q;
	logic [DIV_W-1:0]      rem_q;
	logic [QUOT_W-1:0]     quot_q;
	logic [DIV_W-1:0]      prod;
	logic [RECIP_X_W-1:0]  scaled;
	logic [RECIP_P_W-1:0]  recip_prod;

	// Take a new duration only when the sequencer is free
	assign s_tready = (state_q == F_IDLE);

	// Product of the duration and the carrier, registered before the divider
	assign prod = DIV_W'(dur_q) * DIV_W'(carrier_hz);

	// Divide by one million: drop the factor 64, then multiply by the reciprocal
	assign scaled     = rem_q[DIV_W-1:RECIP_PRE];
	assign recip_prod = RECIP_P_W'(scaled) * RECIP_P_W'(RECIP_M);

	// Hand the saturated period count to the queue
	assign push               = (state_q == F_PUSH) && !full;
	assign push_entry.periods = (quot_q > QUOT_W'(PERIOD_CAP)) ? PERIOD_CAP
		: quot_q[PER_W-1:0];
	assign push_entry.fin     = fin_q;

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (s_tvalid) state_q <= F_MUL;
				F_MUL:  state_q <= F_RND;
				F_RND:  state_q <= F_DIV;
				F_DIV:  state_q <= F_PUSH;
				F_PUSH: if (!full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				dur_q <= s_tdata;
				fin_q <= s_tlast;
			end
			F_MUL: rem_q <= prod;
			F_RND: rem_q <= rem_q + ROUND_HALF;
			F_DIV: quot_q <= recip_prod[RECIP_SHIFT +: QUOT_W];
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

endmodule

// ===== design/irpte_queue.sv =====
// Short queue between the encoder's front and back ends.
// Depends on irpte_pkg for the entry type.
module irpte_queue import irpte_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  irpte_entry_t push_entry,
	output logic         full,
	input  logic         pop,
	output irpte_entry_t pop_entry,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	irpte_entry_t      slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign full      = (fill_q == FILL_W'(DEPTH));
	assign empty     = (fill_q == '0);
	assign pop_entry = slot_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

// ===== design/irpte_back.sv =====
// Back end of the IR pulse-train encoder: splits period counts into code
// bytes, tracks the space flag and frame byte count. Depends on irpte_pkg.
module irpte_back import irpte_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  irpte_entry_t          pop_entry,
	output logic                  pop,
	input  logic [MAXB_W-1:0]     max_bytes,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [BYTE_W-1:0]     m_tdata,
	output logic                  m_tlast,
	output logic [OUT_USER_W-1:0] m_tuser
);

	logic                  active_q;
	logic [PER_W-1:0]      left_q;
	logic                  fin_q;
	logic                  flag_q;
	logic [CNT_W-1:0]      count_q;
	logic                  m_tvalid_q;
	logic [BYTE_W-1:0]     m_tdata_q;
	logic                  m_tlast_q;
	logic [OUT_USER_W-1:0] m_tuser_q;
	logic                  slot_free;
	logic                  emit;
	logic                  is_last;
	logic [BYTE_W-2:0]     byte_periods;
	logic [CNT_W:0]        pos;
	logic                  over;

	assign slot_free    = !m_tvalid_q || m_tready;
	assign pop          = !active_q && !empty;
	assign emit         = active_q && slot_free;
	assign is_last      = (left_q <= BYTE_PERIODS);
	assign byte_periods = is_last ? left_q[BYTE_W-2:0] : BYTE_PERIODS[BYTE_W-2:0];
	assign pos          = {1'b0, count_q} + 1'b1;
	assign over         = (pos > (CNT_W + 1)'(max_bytes));

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	// Control: load entries, step through bytes, update frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			flag_q     <= 1'b0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
			end else if (emit && is_last) begin
				active_q <= 1'b0;
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (emit) begin
				if (is_last && fin_q) begin
					flag_q  <= 1'b0;
					count_q <= '0;
				end else begin
					if (is_last) flag_q <= !flag_q;
					if (count_q != COUNT_MAX) count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// Payload: remaining periods and the output register
	always_ff @(posedge clk) begin
		if (pop) begin
			left_q <= pop_entry.periods;
			fin_q  <= pop_entry.fin;
		end else if (emit) begin
			left_q <= left_q - BYTE_PERIODS;
		end
		if (emit) begin
			m_tdata_q <= {flag_q, byte_periods};
			m_tlast_q <= is_last;
			m_tuser_q <= {over, is_last && fin_q};
		end
	end

endmodule

// ===== design/ir_pulse_train_encoder_core.sv =====
// Top level of the IR pulse-train encoder: configuration registers, front
// end, queue and back end. Depends on irpte_pkg and the irpte_* modules.
//
// Channel | Direction | Handshake          | Contents
// s_*     | in        | s_tvalid/s_tready  | tdata duration_us, tlast final_duration
// m_*     | out       | m_tvalid/m_tready  | tdata code_byte, tlast run_last,
//         |           |                    | tuser frame_end, over_limit
// cfg_*   | in        | cfg_we             | index 0 carrier_hz, 1 max_bytes
//
// For each duration the front end steps through the accept, a multiply, a
// rounding add, a reciprocal multiply for the divide by one million and a
// queue push that waits on a full queue. The back end then sends one byte
// per cycle while the output is ready, 1 to 60 bytes per duration. The two
// run independently through the queue, so a stalled output only holds the
// front once the queue fills. Reset is asynchronous and needs no clearing pass.
module ir_pulse_train_encoder_core import irpte_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DUR_W-1:0]      s_tdata,    // [15:0] duration_us
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [BYTE_W-1:0]     m_tdata,    // [7:0] code_byte
	output logic                  m_tlast,
	output logic [OUT_USER_W-1:0] m_tuser,    // [0] frame_end, [1] over_limit
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CARRIER_W-1:0]  cfg_data
);

	logic [CARRIER_W-1:0] carrier_hz_q;
	logic [MAXB_W-1:0]    max_bytes_q;
	logic                 push;
	logic                 full;
	logic                 pop;
	logic                 empty;
	irpte_entry_t         push_entry;
	irpte_entry_t         pop_entry;

	// Write configuration; drop carrier values outside the legal range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_hz_q <= CARRIER_RESET;
			max_bytes_q  <= MAXB_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CARRIER_HZ: begin
					if (cfg_data >= CARRIER_LOW && cfg_data <= CARRIER_HIGH)
						carrier_hz_q <= cfg_data;
				end
				REG_MAX_BYTES: max_bytes_q <= cfg_data[MAXB_W-1:0];
				default: max_bytes_q <= max_bytes_q;
			endcase
		end
	end

	irpte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.carrier_hz (carrier_hz_q),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	irpte_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (empty)
	);

	irpte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_entry (pop_entry),
		.pop       (pop),
		.max_bytes (max_bytes_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for ir_pulse_train_encoder_core: directed table, then random frames
// checked against a cycle-free encoder prediction. Depends on irpte_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
	import irpte_pkg::*;

	// One code byte as it leaves the block
	typedef struct packed {
		logic [BYTE_W-1:0] code;
		logic              run_last;
		logic              frame_end;
		logic              over_limit;
	} code_byte_t;

	// One row of the directed table: a register write or a duration
	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CARRIER_W-1:0] val;
		logic [DUR_W-1:0]     dur;
		logic                 fin;
		logic                 typed;
		logic [BYTE_W-1:0]    code;
		logic                 fend;
		logic                 over;
	} plan_row_t;

	localparam int N_PLAN = 29;
	localparam int RANDOM_ITEMS = 350;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DUR_W-1:0]      s_tdata;    // [15:0] duration_us
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [BYTE_W-1:0]     m_tdata;    // [7:0] code_byte
	logic                  m_tlast;
	logic [OUT_USER_W-1:0] m_tuser;    // [0] frame_end, [1] over_limit
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CARRIER_W-1:0]  cfg_data;

	// Predicted encoder state and registers
	logic [CARRIER_W-1:0] pr_carrier;
	logic [MAXB_W-1:0]    pr_max_bytes;
	logic                 pr_space;
	logic [CNT_W-1:0]     pr_count;

	code_byte_t owed_bytes[$];
	int  mismatches = 0;
	int  bytes_seen = 0;
	int  durations_sent = 0;
	int  frames_sent = 0;
	int  settings_used = 1;
	bit  tx_gaps = 1'b1;
	bit  rx_gaps = 1'b1;

	// Directed rows: reset values, rounding edges, ignored carrier writes,
	// saturation of the period count and of the frame byte count
	plan_row_t plan [N_PLAN] = '{
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'd13,    1'b0, 1'b1, 8'h80, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'd14,    1'b0, 1'b1, 8'h01, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'd3342,  1'b0, 1'b1, 8'hFF, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'd3356,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'd50000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'hFFFF,  1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_CFG,  REG_CARRIER_HZ, 18'd24999,  16'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_CFG,  REG_CARRIER_HZ, 18'd150001, 16'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_CFG,  REG_CARRIER_HZ, 18'h3FFFF,  16'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_CFG,  REG_MAX_BYTES,  18'h3FF00,  16'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'd0,     1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'd14,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_CFG,  REG_CARRIER_HZ, 18'd150000, 16'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_CFG,  REG_MAX_BYTES,  18'd255,    16'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'hFFFF,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'hFFFF,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'hFFFF,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'hFFFF,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'hFFFF,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'hFFFF,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'hFFFF,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'hFFFF,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'hFFFF,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'hFFFF,  1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_CFG,  REG_CARRIER_HZ, 18'd25000, 16'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_CFG,  REG_MAX_BYTES,  18'd1,     16'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'd20,    1'b0, 1'b1, 8'h01, 1'b0, 1'b0},
		'{ROW_ITEM, REG_CARRIER_HZ, 18'd0, 16'd19,    1'b1, 1'b1, 8'h80, 1'b1, 1'b1}
	};

	ir_pulse_train_encoder_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Toggle the clock, 8 ns period
	always #4 clk = ~clk;

	// Encode one duration into code bytes; advance the frame state and
	// queue the bytes unless the caller supplies its own expectation
	function automatic void encode_duration(input logic [DUR_W-1:0] dur, input logic fin,
			input bit queue_it);
		longint unsigned conv;
		logic [PER_W-1:0] left;
		logic [PER_W-1:0] chunk;
		code_byte_t b;
		conv = (64'(dur) * 64'(pr_carrier) + 64'(ROUND_HALF)) / 64'(US_PER_SECOND);
		left = (conv > 64'(PERIOD_CAP)) ? PERIOD_CAP : PER_W'(conv);
		forever begin
			chunk = (left > BYTE_PERIODS) ? BYTE_PERIODS : left;
			b.code = {pr_space, chunk[6:0]};
			b.run_last = (left <= BYTE_PERIODS);
			b.frame_end = b.run_last & fin;
			b.over_limit = ({1'b0, pr_count} + 10'd1) > {2'b00, pr_max_bytes};
			if (pr_count != COUNT_MAX)
				pr_count = pr_count + 1'b1;
			if (queue_it)
				owed_bytes.push_back(b);
			if (b.run_last)
				break;
			left = left - BYTE_PERIODS;
		end
		if (fin) begin
			pr_space = 1'b0;
			pr_count = '0;
		end else begin
			pr_space = ~pr_space;
		end
	endfunction

	// Offer one duration after a random gap; return at the falling edge after acceptance
	task automatic send_duration(input logic [DUR_W-1:0] dur, input logic fin,
			input bit typed, input code_byte_t typed_byte);
		int gap;
		if ($urandom_range(0, 24) == 0)
			tx_gaps = ~tx_gaps;
		gap = tx_gaps ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= dur;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		encode_duration(dur, fin, !typed);
		if (typed)
			owed_bytes.push_back(typed_byte);
		durations_sent++;
		if (fin)
			frames_sent++;
		@(negedge clk);
	endtask

	// Drop the input valid and hold until every owed byte has come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (owed_bytes.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Write one register and mirror it into the predicted registers
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CARRIER_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_CARRIER_HZ) begin
			if (val >= CARRIER_LOW && val <= CARRIER_HIGH)
				pr_carrier = val;
		end else begin
			pr_max_bytes = val[MAXB_W-1:0];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Output side: stall a random number of cycles per byte
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				rx_gaps = ~rx_gaps;
			stall = rx_gaps ? $urandom_range(0, 12) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// Compare each output transaction with the oldest owed byte
	always @(posedge clk) begin
		code_byte_t got;
		code_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata, m_tlast, m_tuser[0], m_tuser[1]};
			bytes_seen++;
			if (owed_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected byte code %02h last %b end %b over %b",
						$realtime, got.code, got.run_last, got.frame_end, got.over_limit);
			end else begin
				want = owed_bytes.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: byte %0d: expected code %02h last %b end %b over %b,",
							" got code %02h last %b end %b over %b"},
							$realtime, bytes_seen, want.code, want.run_last, want.frame_end,
							want.over_limit, got.code, got.run_last, got.frame_end,
							got.over_limit);
				end
			end
		end
	end

	// Stimulus: reset, directed table, random frames, drain and verdict
	initial begin
		int rand_items;
		int frames_left;
		int len;
		logic [DUR_W-1:0] dur;
		logic [CARRIER_W-1:0] carrier;
		logic [MAXB_W-1:0] mb;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_CARRIER_HZ;
		cfg_data  = '0;
		pr_carrier   = CARRIER_RESET;
		pr_max_bytes = MAXB_RESET;
		pr_space     = 1'b0;
		pr_count     = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(plan[i].idx, plan[i].val);
				settings_used++;
			end else begin
				send_duration(plan[i].dur, plan[i].fin, plan[i].typed,
					'{plan[i].code, 1'b1, plan[i].fend, plan[i].over});
			end
		end

		// Random phases: new settings, then a few frames of random durations
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			wait_idle();
			case ($urandom_range(0, 5))
				0: carrier = CARRIER_LOW;
				1: carrier = CARRIER_HIGH;
				2: carrier = CARRIER_W'($urandom_range(CARRIER_LOW, CARRIER_HIGH));
				3: carrier = CARRIER_W'($urandom());
				4: carrier = $urandom_range(0, 1) ? CARRIER_LOW - 1'b1 : CARRIER_HIGH + 1'b1;
				default: carrier = CARRIER_W'($urandom_range(30000, 60000));
			endcase
			case ($urandom_range(0, 3))
				0: mb = '0;
				1: mb = '1;
				2: mb = MAXB_W'($urandom_range(0, 40));
				default: mb = MAXB_W'($urandom());
			endcase
			write_reg(REG_CARRIER_HZ, carrier);
			write_reg(REG_MAX_BYTES, {(CARRIER_W - MAXB_W)'($urandom()), mb});
			settings_used++;
			frames_left = $urandom_range(2, 6);
			while (frames_left > 0 && rand_items < RANDOM_ITEMS) begin
				len = $urandom_range(1, 14);
				for (int k = 0; k < len; k++) begin
					case ($urandom_range(0, 9))
						0: dur = DUR_W'($urandom());
						1, 2: dur = DUR_W'($urandom_range(0, 50000));
						3: dur = DUR_W'($urandom_range(0, 40));
						default: dur = DUR_W'($urandom_range(0, 4000));
					endcase
					send_duration(dur, k == len - 1, 1'b0, '0);
					rand_items++;
				end
				frames_left--;
			end
		end

		// Drain, then watch for stray bytes
		wait_idle();
		repeat (40) @(posedge clk);
		$display("Sent %0d durations in %0d frames under %0d register settings.",
			durations_sent, frames_sent, settings_used);
		$display("Compared %0d code bytes, %0d mismatched.", bytes_seen, mismatches);
		if (mismatches == 0 && owed_bytes.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#10_000_000;
		$display("Timeout with %0d bytes still owed", owed_bytes.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
